// ----- sv/gte_pkg.sv -----
// Shared codes, widths and defaults for the greedy triangulation edge block.
// No dependencies; every other file of the block depends on this package.
package gte_pkg;

	// Opcodes of an input beat
	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_CLEAR = 2'd0;
	localparam opcode_t OP_LOAD  = 2'd1;
	localparam opcode_t OP_BUILD = 2'd2;
	localparam opcode_t OP_READ  = 2'd3;

	// Result status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_RANGE = 2'd2;

	// Squared length limit register
	localparam int LEN_W = 34;
	localparam logic [LEN_W-1:0] LIMIT_RESET = '1;

	// Default sizing
	localparam int MAX_POINTS_DEF = 32;
	localparam int MAX_PAIRS_DEF  = 496;
	localparam int COORD_BITS_DEF = 16;

	// Multiply-accumulate unit operations
	typedef logic [1:0] mac_op_t;
	localparam mac_op_t MAC_NOP  = 2'd0;
	localparam mac_op_t MAC_LOAD = 2'd1;
	localparam mac_op_t MAC_ADD  = 2'd2;
	localparam mac_op_t MAC_SUB  = 2'd3;

endpackage

// ----- sv/gte_if.sv -----
// Valid/ready channel interfaces: request, response and limit register write.
// Depends on gte_pkg for codes, widths and defaults.
interface gte_req_if #(
	parameter int COORD_BITS = gte_pkg::COORD_BITS_DEF,
	parameter int IDX_W      = 9
);
	logic                         valid;
	logic                         ready;
	gte_pkg::opcode_t             opcode;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;
	logic [IDX_W-1:0]             edge_index;

	modport source (output valid, opcode, coord_x, coord_y, edge_index, input ready);
	modport sink   (input valid, opcode, coord_x, coord_y, edge_index, output ready);
endinterface

interface gte_rsp_if #(
	parameter int END_W = 5,
	parameter int ET_W  = 9,
	parameter int PT_W  = 6
);
	logic             valid;
	logic             ready;
	gte_pkg::status_t status;
	logic [END_W-1:0] end_first;
	logic [END_W-1:0] end_second;
	logic [ET_W-1:0]  edge_total;
	logic [PT_W-1:0]  point_total;

	modport source (output valid, status, end_first, end_second, edge_total, point_total,
		input ready);
	modport sink   (input valid, status, end_first, end_second, edge_total, point_total,
		output ready);
endinterface

interface gte_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [gte_pkg::LEN_W-1:0]    max_edge_sq;

	modport source (output valid, max_edge_sq, input ready);
	modport sink   (input valid, max_edge_sq, output ready);
endinterface

// ----- sv/greedy_triangulation_edges.sv -----
// Greedy triangulation edge builder: top level, sequencer and stores.
// Depends on gte_pkg, the interfaces in gte_if.sv and the shared unit gte_mac.
//
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | opcode, coord_x, coord_y, edge_index
//  rsp     | out | valid/ready | status, end_first, end_second, edge_total, point_total
//  cfg     | in  | valid/ready | max_edge_sq (always ready)
//
// Clear, load and an out-of-range read fill the response register on acceptance; an
// in-range read first passes through the read-edge state. A build runs on one shared
// multiply-accumulate unit and the point and pair stores: each point pair is collected
// in turn, then per sorted candidate a selection scan over the n collected pairs, fetch
// and commit, with an endpoint test per accepted edge and a crossing test for the rest.
// Reset is asynchronous, active low; stores hold no reset and need no clearing.
// req is ready only while idle with the response register free or draining.
module greedy_triangulation_edges #(
	parameter int MAX_POINTS = gte_pkg::MAX_POINTS_DEF,
	parameter int MAX_PAIRS  = gte_pkg::MAX_PAIRS_DEF,
	parameter int COORD_BITS = gte_pkg::COORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	gte_req_if.sink   req,
	gte_rsp_if.source rsp,
	gte_cfg_if.sink   cfg
);
	import gte_pkg::*;

	localparam int PI_W  = $clog2(MAX_POINTS);
	localparam int PC_W  = $clog2(MAX_POINTS + 1);
	localparam int PR_W  = $clog2(MAX_PAIRS);
	localparam int NC_W  = $clog2(MAX_PAIRS + 1);
	localparam int OPW   = COORD_BITS + 1;
	localparam int ACC_W = 2 * COORD_BITS + 4;
	localparam int CMP_W = (ACC_W > LEN_W) ? ACC_W : LEN_W;
	localparam int PT_DW = 2 * COORD_BITS;
	localparam int PR_DW = 2 * PI_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RDE  = 3'd1;
	localparam logic [2:0] S_COL  = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_SEL  = 3'd4;
	localparam logic [2:0] S_CHK  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	function automatic logic signed [OPW-1:0] sx(input logic [COORD_BITS-1:0] v);
		return {v[COORD_BITS-1], v};
	endfunction

	// num/den strictly between 0 and 1, zero denominator gives false
	function automatic logic ratio_inside(input logic signed [ACC_W-1:0] num,
		input logic signed [ACC_W-1:0] den);
		logic r;
		r = 1'b0;
		if (den > 0)
			r = (num > 0) && (num < den);
		else if (den < 0)
			r = (num < 0) && (num > den);
		return r;
	endfunction

	// control
	logic [2:0]       state_q;
	logic [3:0]       st_q;
	logic [PC_W-1:0]  pt_cnt_q;
	logic [NC_W-1:0]  n_q, acc_cnt_q, sk_q, ak_q;
	logic [PC_W-1:0]  i_q, j_q;
	logic             chk_v_q, found_q, have_prev_q, ok_q;
	logic [PR_W-1:0]  chk_idx_q, bidx_q, pidx_q;
	logic [LEN_W-1:0] blen_q, plen_q, lim_q;
	logic [PR_DW-1:0] e_q, f_q;
	logic [PT_DW-1:0] a_q, c_q;
	logic signed [OPW-1:0]   ux_q, uy_q, vx_q, vy_q, wx_q, wy_q;
	logic signed [ACC_W-1:0] np_q, dp_q;

	// response register
	logic             out_v_q;
	status_t          o_status_q;
	logic [PI_W-1:0]  o_e1_q, o_e2_q;
	logic [NC_W-1:0]  o_et_q;
	logic [PC_W-1:0]  o_pt_q;

	// stores
	logic [PT_DW-1:0] pt_mem [MAX_POINTS];
	logic [PR_DW-1:0] pair_mem [MAX_PAIRS];
	logic [LEN_W-1:0] len_mem [MAX_PAIRS];
	logic [PR_DW-1:0] acc_mem [MAX_PAIRS];
	logic [PT_DW-1:0] pt_rd_q;
	logic [PR_DW-1:0] pr_rd_q, ac_rd_q;
	logic [LEN_W-1:0] len_rd_q;

	logic [PI_W-1:0]  pt_raddr;
	logic [PR_W-1:0]  pr_raddr, ac_raddr;
	logic             pt_we, pr_we, ac_we;

	// shared unit
	logic signed [OPW-1:0]   mac_a, mac_b;
	mac_op_t                 mac_op;
	logic signed [ACC_W-1:0] mac_acc;

	logic             accept, col_hit, col_last, gt_prev, lt_best, shared, crossing, chk_done;
	logic             out_set;
	logic [CMP_W-1:0] len_ext;
	logic [NC_W-1:0]  n_nx;

	gte_mac #(.OPW(OPW), .ACC_W(ACC_W)) u_mac (
		.clk(clk), .arst_n(arst_n), .a(mac_a), .b(mac_b), .op(mac_op), .acc(mac_acc)
	);

	assign req.ready = (state_q == S_IDLE) && (!out_v_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// a new response beat is loaded this cycle
	assign out_set = (accept && (req.opcode != OP_BUILD) &&
		!((req.opcode == OP_READ) && (req.edge_index < acc_cnt_q))) ||
		(state_q == S_RDE) || (state_q == S_FIN);

	// decisions
	assign len_ext  = CMP_W'($unsigned(mac_acc));
	assign col_hit  = len_ext < CMP_W'(lim_q);
	assign col_last = (j_q == pt_cnt_q - PC_W'(1)) && ((i_q + PC_W'(2)) >= pt_cnt_q);
	assign n_nx     = n_q + NC_W'(col_hit);
	assign gt_prev  = !have_prev_q || (len_rd_q > plen_q) ||
		((len_rd_q == plen_q) && (chk_idx_q > pidx_q));
	assign lt_best  = !found_q || (len_rd_q < blen_q) ||
		((len_rd_q == blen_q) && (chk_idx_q < bidx_q));
	assign shared   = (e_q[PR_DW-1:PI_W] == ac_rd_q[PR_DW-1:PI_W]) ||
		(e_q[PR_DW-1:PI_W] == ac_rd_q[PI_W-1:0]) ||
		(e_q[PI_W-1:0] == ac_rd_q[PR_DW-1:PI_W]) ||
		(e_q[PI_W-1:0] == ac_rd_q[PI_W-1:0]);
	assign crossing = ratio_inside(np_q, dp_q) && ratio_inside(mac_acc, -dp_q);
	assign chk_done = (ak_q >= acc_cnt_q) || !ok_q;

	assign pt_we = accept && (req.opcode == OP_LOAD) && (pt_cnt_q != PC_W'(MAX_POINTS));
	assign pr_we = (state_q == S_COL) && (st_q == 4'd6) && col_hit;
	assign ac_we = (state_q == S_CHK) && (st_q == 4'd0) && chk_done && ok_q;

	// read addresses and shared unit operands
	always_comb begin
		pt_raddr = '0;
		pr_raddr = sk_q[PR_W-1:0];
		ac_raddr = ak_q[PR_W-1:0];
		mac_a    = '0;
		mac_b    = '0;
		mac_op   = MAC_NOP;
		unique case (state_q)
			S_IDLE: ac_raddr = req.edge_index[PR_W-1:0];
			S_COL: begin
				if (st_q == 4'd0) pt_raddr = i_q[PI_W-1:0];
				if (st_q == 4'd1) pt_raddr = j_q[PI_W-1:0];
				if (st_q == 4'd3) begin
					mac_a = ux_q; mac_b = ux_q; mac_op = MAC_LOAD;
				end
				if (st_q == 4'd4) begin
					mac_a = uy_q; mac_b = uy_q; mac_op = MAC_ADD;
				end
			end
			S_SEL: begin
				pr_raddr = bidx_q;
				if (st_q == 4'd2) pt_raddr = e_q[PR_DW-1:PI_W];
				if (st_q == 4'd3) pt_raddr = e_q[PI_W-1:0];
			end
			S_CHK: begin
				if (st_q == 4'd2) pt_raddr = f_q[PR_DW-1:PI_W];
				if (st_q == 4'd3) pt_raddr = f_q[PI_W-1:0];
				unique case (st_q)
					4'd5: begin mac_a = vx_q; mac_b = wy_q; mac_op = MAC_LOAD; end
					4'd6: begin mac_a = vy_q; mac_b = wx_q; mac_op = MAC_SUB; end
					4'd7: begin mac_a = ux_q; mac_b = vy_q; mac_op = MAC_LOAD; end
					4'd8: begin mac_a = uy_q; mac_b = vx_q; mac_op = MAC_SUB; end
					4'd9: begin mac_a = uy_q; mac_b = wx_q; mac_op = MAC_LOAD; end
					4'd10: begin mac_a = ux_q; mac_b = wy_q; mac_op = MAC_SUB; end
					default: mac_op = MAC_NOP;
				endcase
			end
			default: mac_op = MAC_NOP;
		endcase
	end

	// point store
	always_ff @(posedge clk) begin
		if (pt_we)
			pt_mem[pt_cnt_q[PI_W-1:0]] <= {req.coord_x, req.coord_y};
		pt_rd_q <= pt_mem[pt_raddr];
	end

	// candidate pair and length stores
	always_ff @(posedge clk) begin
		if (pr_we) begin
			pair_mem[n_q[PR_W-1:0]] <= {i_q[PI_W-1:0], j_q[PI_W-1:0]};
			len_mem[n_q[PR_W-1:0]]  <= len_ext[LEN_W-1:0];
		end
		pr_rd_q  <= pair_mem[pr_raddr];
		len_rd_q <= len_mem[pr_raddr];
	end

	// accepted edge store
	always_ff @(posedge clk) begin
		if (ac_we)
			acc_mem[acc_cnt_q[PR_W-1:0]] <= e_q;
		ac_rd_q <= acc_mem[ac_raddr];
	end

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lim_q <= LIMIT_RESET;
		else if (cfg.valid && cfg.ready)
			lim_q <= cfg.max_edge_sq;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; st_q <= '0;
			pt_cnt_q <= '0; n_q <= '0; acc_cnt_q <= '0; sk_q <= '0; ak_q <= '0;
			i_q <= '0; j_q <= '0;
			chk_v_q <= 1'b0; found_q <= 1'b0; have_prev_q <= 1'b0; ok_q <= 1'b0;
			chk_idx_q <= '0; bidx_q <= '0; pidx_q <= '0;
			blen_q <= '0; plen_q <= '0; e_q <= '0; f_q <= '0; a_q <= '0; c_q <= '0;
			ux_q <= '0; uy_q <= '0; vx_q <= '0; vy_q <= '0; wx_q <= '0; wy_q <= '0;
			np_q <= '0; dp_q <= '0;
			out_v_q <= 1'b0; o_status_q <= ST_OK; o_e1_q <= '0; o_e2_q <= '0;
			o_et_q <= '0; o_pt_q <= '0;
		end else begin
			if (out_set)
				out_v_q <= 1'b1;
			else if (rsp.valid && rsp.ready)
				out_v_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						o_e1_q     <= '0;
						o_e2_q     <= '0;
						o_et_q     <= acc_cnt_q;
						unique case (req.opcode)
							OP_CLEAR: begin
								pt_cnt_q   <= '0;
								o_pt_q     <= '0;
								o_status_q <= ST_OK;
							end
							OP_LOAD: begin
								if (pt_cnt_q == PC_W'(MAX_POINTS)) begin
									o_status_q <= ST_FULL;
									o_pt_q     <= pt_cnt_q;
								end else begin
									o_status_q <= ST_OK;
									pt_cnt_q   <= pt_cnt_q + PC_W'(1);
									o_pt_q     <= pt_cnt_q + PC_W'(1);
								end
							end
							OP_BUILD: begin
								n_q       <= '0;
								acc_cnt_q <= '0;
								i_q       <= '0;
								j_q       <= PC_W'(1);
								st_q      <= '0;
								state_q   <= (pt_cnt_q < PC_W'(2)) ? S_FIN : S_COL;
							end
							default: begin
								o_pt_q <= pt_cnt_q;
								if (req.edge_index >= acc_cnt_q) begin
									o_status_q <= ST_RANGE;
								end else begin
									o_status_q <= ST_OK;
									state_q    <= S_RDE;
								end
							end
						endcase
					end
				end

				S_RDE: begin
					o_e1_q  <= ac_rd_q[PR_DW-1:PI_W];
					o_e2_q  <= ac_rd_q[PI_W-1:0];
					state_q <= S_IDLE;
				end

				// collect pairs under the limit, generation order
				S_COL: begin
					if (st_q != 4'd6)
						st_q <= st_q + 4'd1;
					if (st_q == 4'd1)
						a_q <= pt_rd_q;
					if (st_q == 4'd2) begin
						ux_q <= sx(a_q[PT_DW-1:COORD_BITS]) - sx(pt_rd_q[PT_DW-1:COORD_BITS]);
						uy_q <= sx(a_q[COORD_BITS-1:0]) - sx(pt_rd_q[COORD_BITS-1:0]);
					end
					if (st_q == 4'd6) begin
						n_q  <= n_nx;
						st_q <= '0;
						if (col_last || n_nx == NC_W'(MAX_PAIRS)) begin
							sk_q        <= '0;
							chk_v_q     <= 1'b0;
							found_q     <= 1'b0;
							have_prev_q <= 1'b0;
							state_q     <= (n_nx == '0) ? S_FIN : S_SCAN;
						end else if (j_q == pt_cnt_q - PC_W'(1)) begin
							i_q <= i_q + PC_W'(1);
							j_q <= i_q + PC_W'(2);
						end else begin
							j_q <= j_q + PC_W'(1);
						end
					end
				end

				// find the next pair in (length, index) order
				S_SCAN: begin
					if (chk_v_q && gt_prev && lt_best) begin
						found_q <= 1'b1;
						blen_q  <= len_rd_q;
						bidx_q  <= chk_idx_q;
					end
					if (sk_q < n_q) begin
						sk_q      <= sk_q + NC_W'(1);
						chk_v_q   <= 1'b1;
						chk_idx_q <= sk_q[PR_W-1:0];
					end else begin
						chk_v_q <= 1'b0;
						if (!chk_v_q) begin
							st_q    <= '0;
							state_q <= found_q ? S_SEL : S_FIN;
						end
					end
				end

				// fetch the chosen pair and its end points
				S_SEL: begin
					if (st_q != 4'd4)
						st_q <= st_q + 4'd1;
					if (st_q == 4'd1)
						e_q <= pr_rd_q;
					if (st_q == 4'd3)
						a_q <= pt_rd_q;
					if (st_q == 4'd4) begin
						ux_q <= sx(pt_rd_q[PT_DW-1:COORD_BITS]) - sx(a_q[PT_DW-1:COORD_BITS]);
						uy_q <= sx(pt_rd_q[COORD_BITS-1:0]) - sx(a_q[COORD_BITS-1:0]);
						plen_q      <= blen_q;
						pidx_q      <= bidx_q;
						have_prev_q <= 1'b1;
						ak_q        <= '0;
						ok_q        <= 1'b1;
						st_q        <= '0;
						state_q     <= S_CHK;
					end
				end

				// test against the accepted edges, stopping at the first crossing
				S_CHK: begin
					if (!((st_q == 4'd0 && chk_done) || (st_q == 4'd1 && shared) ||
						st_q == 4'd12))
						st_q <= st_q + 4'd1;
					if (st_q == 4'd0 && chk_done) begin
						if (ok_q)
							acc_cnt_q <= acc_cnt_q + NC_W'(1);
						sk_q    <= '0;
						chk_v_q <= 1'b0;
						found_q <= 1'b0;
						st_q    <= '0;
						state_q <= S_SCAN;
					end
					if (st_q == 4'd1) begin
						f_q <= ac_rd_q;
						if (shared) begin
							ak_q <= ak_q + NC_W'(1);
							st_q <= '0;
						end
					end
					if (st_q == 4'd3) begin
						c_q  <= pt_rd_q;
						wx_q <= sx(a_q[PT_DW-1:COORD_BITS]) - sx(pt_rd_q[PT_DW-1:COORD_BITS]);
						wy_q <= sx(a_q[COORD_BITS-1:0]) - sx(pt_rd_q[COORD_BITS-1:0]);
					end
					if (st_q == 4'd4) begin
						vx_q <= sx(pt_rd_q[PT_DW-1:COORD_BITS]) - sx(c_q[PT_DW-1:COORD_BITS]);
						vy_q <= sx(pt_rd_q[COORD_BITS-1:0]) - sx(c_q[COORD_BITS-1:0]);
					end
					if (st_q == 4'd8)
						np_q <= mac_acc;
					if (st_q == 4'd10)
						dp_q <= mac_acc;
					if (st_q == 4'd12) begin
						if (crossing)
							ok_q <= 1'b0;
						ak_q <= ak_q + NC_W'(1);
						st_q <= '0;
					end
				end

				S_FIN: begin
					o_status_q <= ST_OK;
					o_e1_q     <= '0;
					o_e2_q     <= '0;
					o_et_q     <= acc_cnt_q;
					o_pt_q     <= pt_cnt_q;
					state_q    <= S_IDLE;
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.status      = o_status_q;
	assign rsp.end_first   = o_e1_q;
	assign rsp.end_second  = o_e2_q;
	assign rsp.edge_total  = o_et_q;
	assign rsp.point_total = o_pt_q;

	// checks
	a_acc_le_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		acc_cnt_q <= n_q)
		else $error("accepted edges exceed collected pairs");

	a_pts_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pt_cnt_q <= PC_W'(MAX_POINTS))
		else $error("point count beyond store depth");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDE || state_q == S_FIN) |-> !out_v_q)
		else $error("response register overwritten");

	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEL) |-> (NC_W'(bidx_q) < n_q))
		else $error("selected pair outside collected set");

endmodule

// ----- sv/gte_mac.sv -----
// Shared signed multiply-accumulate unit: registered product, then accumulate.
// Depends on gte_pkg for the operation codes. Result passes the product and accumulate registers.
module gte_mac #(
	parameter int OPW   = 17,
	parameter int ACC_W = 36
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [OPW-1:0]   a,
	input  logic signed [OPW-1:0]   b,
	input  gte_pkg::mac_op_t        op,
	output logic signed [ACC_W-1:0] acc
);
	import gte_pkg::*;

	logic signed [2*OPW-1:0] prod_s1;
	mac_op_t                 op_s1;
	logic signed [ACC_W-1:0] prod_ext;
	logic signed [ACC_W-1:0] acc_q;

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1   <= MAC_NOP;
			prod_s1 <= '0;
		end else begin
			op_s1   <= op;
			prod_s1 <= a * b;
		end
	end

	assign prod_ext = ACC_W'(prod_s1);

	// accumulate stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			unique case (op_s1)
				MAC_LOAD: acc_q <= prod_ext;
				MAC_ADD:  acc_q <= acc_q + prod_ext;
				MAC_SUB:  acc_q <= acc_q - prod_ext;
				default:  acc_q <= acc_q;
			endcase
		end
	end

	assign acc = acc_q;

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking bench for greedy_triangulation_edges: drives clear, point, build and read beats,
// predicts each response with an internal greedy builder and compares field by field.
// Depends on gte_pkg, the channel interfaces in gte_if.sv and the block itself.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import gte_pkg::*;

	localparam int NPTS       = MAX_POINTS_DEF;
	localparam int NPAIRS     = MAX_PAIRS_DEF;
	localparam longint LIMIT  = 20000000;
	localparam logic [LEN_W-1:0] LIM_MAX = '1;

	typedef struct packed {
		status_t    status;
		logic [4:0] end_first;
		logic [4:0] end_second;
		logic [8:0] edge_total;
		logic [5:0] point_total;
	} rsp_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gte_req_if req_ch();
	gte_rsp_if rsp_ch();
	gte_cfg_if cfg_ch();

	greedy_triangulation_edges u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow state of the block
	longint           pt_x [NPTS];
	longint           pt_y [NPTS];
	int               pt_cnt;
	int               cand_a [NPAIRS];
	int               cand_b [NPAIRS];
	longint           cand_len [NPAIRS];
	int               edge_a [NPAIRS];
	int               edge_b [NPAIRS];
	int               edge_cnt;
	logic [LEN_W-1:0] len_limit;

	rsp_beat_t rsp_expected[$];
	int        mismatches = 0;
	int        burst_left = 0;
	logic      hold_kick = 1'b0;
	int        hold_cnt = 0;
	int        stall_mode = 0;
	longint    cycles = 0;

	// ratio num/den strictly inside (0,1); zero den never inside
	function automatic bit in_open_unit(longint num, longint den);
		if (den > 0) return num > 0 && num < den;
		if (den < 0) return num < 0 && num > den;
		return 1'b0;
	endfunction

	function automatic bit segments_cross(int a, int b, int c, int d);
		longint np, dp, nq, dq;
		np = (pt_x[d] - pt_x[c]) * (pt_y[a] - pt_y[c]) -
			(pt_y[d] - pt_y[c]) * (pt_x[a] - pt_x[c]);
		dp = (pt_x[b] - pt_x[a]) * (pt_y[d] - pt_y[c]) -
			(pt_y[b] - pt_y[a]) * (pt_x[d] - pt_x[c]);
		nq = (pt_x[b] - pt_x[a]) * (pt_y[c] - pt_y[a]) -
			(pt_y[b] - pt_y[a]) * (pt_x[c] - pt_x[a]);
		dq = (pt_x[d] - pt_x[c]) * (pt_y[b] - pt_y[a]) -
			(pt_y[d] - pt_y[c]) * (pt_x[b] - pt_x[a]);
		return in_open_unit(np, dp) && in_open_unit(nq, dq);
	endfunction

	// collect short pairs, stable sort by length, accept non-crossing ones
	function automatic void greedy_build();
		int n, k, ta, tb;
		longint l, dx, dy;
		bit ok;
		n = 0;
		for (int i = 0; i < pt_cnt; i++)
			for (int j = i + 1; j < pt_cnt; j++) begin
				dx = pt_x[i] - pt_x[j];
				dy = pt_y[i] - pt_y[j];
				l = dx * dx + dy * dy;
				if (l < longint'(len_limit) && n < NPAIRS) begin
					cand_a[n] = i;
					cand_b[n] = j;
					cand_len[n] = l;
					n++;
				end
			end
		for (int i = 1; i < n; i++) begin
			ta = cand_a[i];
			tb = cand_b[i];
			l = cand_len[i];
			k = i;
			while (k > 0 && cand_len[k-1] > l) begin
				cand_a[k] = cand_a[k-1];
				cand_b[k] = cand_b[k-1];
				cand_len[k] = cand_len[k-1];
				k--;
			end
			cand_a[k] = ta;
			cand_b[k] = tb;
			cand_len[k] = l;
		end
		edge_cnt = 0;
		for (int i = 0; i < n; i++) begin
			ok = 1'b1;
			for (int j = 0; j < edge_cnt && ok; j++) begin
				if (cand_a[i] == edge_a[j] || cand_a[i] == edge_b[j] ||
					cand_b[i] == edge_a[j] || cand_b[i] == edge_b[j])
					continue;
				if (segments_cross(cand_a[i], cand_b[i], edge_a[j], edge_b[j]))
					ok = 1'b0;
			end
			if (ok) begin
				edge_a[edge_cnt] = cand_a[i];
				edge_b[edge_cnt] = cand_b[i];
				edge_cnt++;
			end
		end
	endfunction

	function automatic void predict_response(opcode_t op, logic signed [15:0] x,
		logic signed [15:0] y, logic [8:0] idx);
		rsp_beat_t r;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_CLEAR: pt_cnt = 0;
			OP_LOAD: begin
				if (pt_cnt >= NPTS) r.status = ST_FULL;
				else begin
					pt_x[pt_cnt] = x;
					pt_y[pt_cnt] = y;
					pt_cnt++;
				end
			end
			OP_BUILD: greedy_build();
			default: begin
				if (int'(idx) >= edge_cnt) r.status = ST_RANGE;
				else begin
					r.end_first = 5'(edge_a[idx]);
					r.end_second = 5'(edge_b[idx]);
				end
			end
		endcase
		r.edge_total = 9'(edge_cnt);
		r.point_total = 6'(pt_cnt);
		rsp_expected.push_back(r);
	endfunction

	// one request beat; bursts of random length separated by random gaps
	task automatic send_req(opcode_t op, logic signed [15:0] x = 0, logic signed [15:0] y = 0,
		logic [8:0] idx = 0);
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.coord_x <= x;
		req_ch.coord_y <= y;
		req_ch.edge_index <= idx;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predict_response(op, x, y, idx);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (rsp_expected.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(logic [LEN_W-1:0] v);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.max_edge_sq <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		len_limit = v;
	endtask

	task automatic read_all_edges();
		for (int i = 0; i <= edge_cnt; i++) send_req(OP_READ, 0, 0, i);
	endtask

	// reads before any build, build on an empty store
	task automatic test_empty_store();
		send_req(OP_READ, 0, 0, 0);
		send_req(OP_BUILD);
		send_req(OP_READ, 0, 0, 9'h1FF);
	endtask

	// extreme coordinates at the corners, full-scale lengths
	task automatic test_extreme_coords();
		send_req(OP_CLEAR);
		send_req(OP_LOAD, -32768, -32768);
		send_req(OP_LOAD, 32767, 32767);
		send_req(OP_LOAD, -32768, 32767);
		send_req(OP_LOAD, 32767, -32768);
		send_req(OP_BUILD);
		read_all_edges();
	endtask

	// square with tied sides and crossing diagonals, plus collinear points
	task automatic test_crossings();
		send_req(OP_CLEAR);
		send_req(OP_LOAD, 0, 0);
		send_req(OP_LOAD, 10, 0);
		send_req(OP_LOAD, 10, 10);
		send_req(OP_LOAD, 0, 10);
		send_req(OP_LOAD, 5, 5);
		send_req(OP_LOAD, 20, 0);
		send_req(OP_LOAD, 30, 0);
		send_req(OP_BUILD);
		read_all_edges();
	endtask

	// fill the store, overflow it, build under a tight limit, clear keeps edges
	task automatic test_full_store();
		write_limit(34'd30);
		send_req(OP_CLEAR);
		for (int i = 0; i < NPTS + 2; i++)
			send_req(OP_LOAD, (i % 8) * 4, (i / 8) * 5);
		send_req(OP_BUILD);
		send_req(OP_READ, 0, 0, 0);
		send_req(OP_READ, 0, 0, edge_cnt - 1);
		send_req(OP_CLEAR);
		send_req(OP_READ, 0, 0, 1);
		send_req(OP_READ, 0, 0, edge_cnt);
	endtask

	// limit extremes: zero collects nothing, one keeps only coincident points
	task automatic test_limit_extremes();
		write_limit(34'd0);
		send_req(OP_CLEAR);
		send_req(OP_LOAD, 1, 1);
		send_req(OP_LOAD, 1, 1);
		send_req(OP_LOAD, 2, 1);
		send_req(OP_BUILD);
		send_req(OP_READ, 0, 0, 0);
		write_limit(34'd1);
		send_req(OP_BUILD);
		send_req(OP_READ, 0, 0, 0);
		write_limit(LIM_MAX);
	endtask

	function automatic logic signed [15:0] pick_coord(int style);
		case (style)
			0: return $urandom_range(0, 12) - 6;
			1: return $urandom();
			default: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
		endcase
	endfunction

	// well-formed clear/load/build/read sequences with some noise
	task automatic test_random_sequences(int target);
		int sent, k, style, r;
		opcode_t op;
		sent = 0;
		while (sent < target) begin
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 4))
					0: write_limit(LIM_MAX);
					1: write_limit('0);
					2: write_limit($urandom_range(1, 200));
					3: write_limit(LEN_W'({$urandom(), $urandom()}));
					default: write_limit($urandom_range(1, 40000));
				endcase
			end
			if ($urandom_range(0, 9) != 0) begin
				send_req(OP_CLEAR);
				sent++;
			end
			style = $urandom_range(0, 4) < 3 ? 0 : $urandom_range(1, 2);
			k = $urandom_range(2, 8);
			for (int i = 0; i < k && pt_cnt < 10; i++) begin
				send_req(OP_LOAD, pick_coord(style), pick_coord(style));
				sent++;
			end
			send_req(OP_BUILD);
			sent++;
			r = $urandom_range(1, 6);
			for (int i = 0; i < r; i++) begin
				if ($urandom_range(0, 4) == 0 || edge_cnt == 0)
					send_req(OP_READ, 0, 0, $urandom_range(0, 511));
				else
					send_req(OP_READ, 0, 0, $urandom_range(0, edge_cnt - 1));
				sent++;
			end
			// noise: random opcodes and fields, builds kept cheap
			if ($urandom_range(0, 3) == 0) begin
				for (int i = 0; i < $urandom_range(1, 4); i++) begin
					op = opcode_t'($urandom_range(0, 3));
					if (op == OP_BUILD && pt_cnt > 10) op = OP_READ;
					if (op == OP_LOAD && pt_cnt >= 10) op = OP_CLEAR;
					send_req(op, $urandom(), $urandom(), $urandom());
					sent++;
				end
			end
		end
	endtask

	// long response hold-off while requests keep coming
	task automatic test_backpressure();
		send_req(OP_CLEAR);
		fork
			begin
				hold_kick <= 1'b1;
				@(posedge clk);
				hold_kick <= 1'b0;
			end
		join_none
		burst_left = 40;
		for (int i = 0; i < 30; i++)
			if (i % 3 == 2) send_req(OP_READ, 0, 0, i);
			else send_req(OP_LOAD, i, i * i % 7);
		send_req(OP_BUILD);
		read_all_edges();
	endtask

	// response stall pattern, with a counted hold-off on request
	always @(posedge clk) begin
		if (hold_kick)
			hold_cnt <= 300;
		else if (hold_cnt != 0)
			hold_cnt <= hold_cnt - 1;
		if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 2);
		if (hold_kick || hold_cnt > 1)
			rsp_ch.ready <= 1'b0;
		else case (stall_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= 1'($urandom_range(0, 1));
			default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// response checker
	always @(posedge clk) begin
		rsp_beat_t exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (rsp_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response beat at cycle %0d", cycles);
			end else begin
				exp_r = rsp_expected.pop_front();
				if (rsp_ch.status !== exp_r.status || rsp_ch.end_first !== exp_r.end_first ||
					rsp_ch.end_second !== exp_r.end_second ||
					rsp_ch.edge_total !== exp_r.edge_total ||
					rsp_ch.point_total !== exp_r.point_total) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch %0d (got/exp): st %0d/%0d e1 %0d/%0d e2 %0d/%0d %s",
							cycles, rsp_ch.status, exp_r.status,
							rsp_ch.end_first, exp_r.end_first,
							rsp_ch.end_second, exp_r.end_second,
							$sformatf("et %0d/%0d pt %0d/%0d",
								rsp_ch.edge_total, exp_r.edge_total,
								rsp_ch.point_total, exp_r.point_total));
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		req_ch.valid <= 1'b0;
		req_ch.opcode <= OP_CLEAR;
		req_ch.coord_x <= '0;
		req_ch.coord_y <= '0;
		req_ch.edge_index <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.max_edge_sq <= '0;
		pt_cnt = 0;
		edge_cnt = 0;
		len_limit = LIMIT_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_store();
		test_extreme_coords();
		test_crossings();
		test_full_store();
		test_limit_extremes();
		test_backpressure();
		test_random_sequences(1450);
		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && rsp_expected.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ----- filelist.f -----
sv/gte_pkg.sv
sv/gte_if.sv
sv/gte_mac.sv
sv/greedy_triangulation_edges.sv
tb/sv/testbench.sv
